### hdl/qts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_pkg - shared types and saturating arithmetic
// Fixed point value type, request and response structs of the shared
// arithmetic units, and the saturating add, subtract and sign helpers.
// ----------------------------------------------------------------------------
package qts_pkg;

	typedef logic signed [63:0] q_t;

	localparam q_t Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;

	// Event kinds carried by the op field.
	localparam logic OP_EXTERNAL = 1'b0;
	localparam logic OP_INTERNAL = 1'b1;

	// Integer value of the "never" time before it is moved into fixed point.
	localparam logic [63:0] NEVER_INT = 64'd10000000000;

	typedef struct packed {
		logic start;
		q_t   a;
		q_t   b;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic sq_mode;
		q_t   a;
		q_t   b;
	} dsq_req_t;

	typedef struct packed {
		logic done;
		q_t   value;
	} unit_rsp_t;

	function automatic q_t sat_add(input q_t a, input q_t b);
		logic signed [64:0] s;
		q_t r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) r = s[64] ? Q_MIN : Q_MAX;
		else r = s[63:0];
		return r;
	endfunction

	function automatic q_t sat_sub(input q_t a, input q_t b);
		logic signed [64:0] s;
		q_t r;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) r = s[64] ? Q_MIN : Q_MAX;
		else r = s[63:0];
		return r;
	endfunction

	function automatic q_t sat_neg(input q_t a);
		q_t r;
		r = (a == Q_MIN) ? Q_MAX : q_t'(64'd0 - a);
		return r;
	endfunction

	// Halving that truncates toward zero.
	function automatic q_t div2_trunc(input q_t a);
		q_t r;
		r = a[63] ? q_t'((a + 64'sd1) >>> 1) : q_t'(a >>> 1);
		return r;
	endfunction

	function automatic logic [63:0] mag(input q_t a);
		logic [63:0] r;
		r = a[63] ? (64'd0 - a) : a;
		return r;
	endfunction

	function automatic q_t from_mag(input logic neg, input logic [63:0] m);
		q_t r;
		if (neg) r = m[63] ? Q_MIN : q_t'(64'd0 - m);
		else r = m[63] ? Q_MAX : q_t'(m);
		return r;
	endfunction

endpackage

### hdl/quadratic_trajectory_switch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_trajectory_switch_unit - switch over four quadratic trajectories
// Event driven switch with crossing detection in saturating signed fixed
// point, built around one shared multiplier and one divide/root unit.
// ----------------------------------------------------------------------------
// Usage. Events arrive as beats on the evt channel (evt_valid, evt_stall);
// op selects an external event (new trajectory on a port, with elapsed
// time) or an internal event (emit the selected trajectory, then move on).
// Every event produces exactly one result beat on the res channel
// (res_valid, res_stall) carrying out_valid, the emitted coefficients and
// next_time, the time advance until the next internal event.
// The block works on one event at a time: evt_stall is high from the beat
// that starts an event until its result beat has been taken. A stalled
// result simply holds in the output registers and the block waits.
// The sequencer steps the shared units in turn. Ageing one trajectory
// takes four multiplies. An internal event with zero time advance skips
// the ageing. An external event on ports 2 and 3 adds the crossing solve.
// Reset clears all trajectories, deselects trajectory 1 and sets both the
// time advance and the crossing time to "never" (1e10 in fixed point,
// saturated to the largest value when it does not fit).
// ----------------------------------------------------------------------------
module quadratic_trajectory_switch_unit #(
	parameter int FRAC_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      evt_valid,
	output logic                      evt_stall,
	input  logic                      op,
	input  logic [1:0]                port,
	input  logic signed [63:0]        level,
	input  logic signed [63:0]        slope,
	input  logic signed [63:0]        curve,
	input  logic [62:0]               elapsed,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic                      out_valid,
	output logic signed [63:0]        out_level,
	output logic signed [63:0]        out_slope,
	output logic signed [63:0]        out_curve,
	output logic [62:0]               next_time
);

	// "Never" in the configured fixed point format, saturated if too large.
	localparam qts_pkg::q_t NEVER =
		(qts_pkg::NEVER_INT > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS)) ?
		qts_pkg::Q_MAX : qts_pkg::q_t'(qts_pkg::NEVER_INT << FRAC_BITS);

	typedef enum logic [4:0] {
		S_IDLE, S_AG1, S_AG2, S_AG3, S_AG4, S_AGN, S_LOAD,
		S_SV0, S_SVBR, S_SVLIN, S_SVBB, S_SVAC, S_SVDISC, S_SVSQ,
		S_SVR1, S_SVR2, S_SVPICK, S_EXT,
		S_INTAB, S_INTBR, S_INTDIV, S_INTFIN, S_OUT
	} state_t;

	state_t state_q;

	// Trajectory state and event bookkeeping.
	qts_pkg::q_t lv_q [4];
	qts_pkg::q_t sl_q [4];
	qts_pkg::q_t cv_q [4];
	qts_pkg::q_t ta_q, ct_q;
	logic        sel_q, chg_q;

	// Latched event and working registers of the sequencer.
	logic        op_q, due_q, skip_q, wait_q;
	logic [1:0]  port_q, idx_q;
	qts_pkg::q_t nlv_q, nsl_q, ncv_q, el_q, dt_q;
	qts_pkg::q_t t1_q, t2_q, ca_q, cb_q, cc_q, nb_q, sq_q, s1_q, s2_q;
	logic        res_ov_q;
	qts_pkg::q_t res_lv_q, res_sl_q, res_cv_q;

	qts_pkg::mul_req_t  mreq;
	qts_pkg::dsq_req_t  dreq;
	qts_pkg::unit_rsp_t mrsp, drsp;

	logic        skip_now, gt23, lt23, int_cross;
	logic [1:0]  ksel, csel;
	qts_pkg::q_t ct_sub, ct_dec, s1c, s2c, div_c;

	qts_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.rsp   (mrsp)
	);

	qts_dsq #(.FRAC_BITS(FRAC_BITS)) u_dsq (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	always_comb begin
		skip_now  = skip_q && (idx_q == port_q);
		gt23      = lv_q[2] > lv_q[3];
		lt23      = lv_q[2] < lv_q[3];
		ksel      = {1'b0, ~sel_q};
		csel      = {1'b0, sel_q};
		int_cross = (cb_q[63] && !ca_q[63] && (ca_q != '0)) ||
			(!cb_q[63] && (cb_q != '0) && ca_q[63]);
		// Crossing countdown for events on ports 0 and 1.
		ct_sub    = qts_pkg::sat_sub(ct_q, el_q);
		ct_dec    = (ct_q == NEVER) ? ct_q : (ct_sub[63] ? '0 : ct_sub);
		s1c       = (s1_q > NEVER) ? NEVER : s1_q;
		s2c       = (s2_q > NEVER) ? NEVER : s2_q;
		div_c     = (drsp.value > NEVER) ? NEVER : drsp.value;
	end

	// Operand steering into the shared units.
	always_comb begin
		mreq = '0;
		dreq = '0;
		unique case (state_q)
			S_AG1: begin
				mreq.a     = sl_q[idx_q];
				mreq.b     = dt_q;
				mreq.start = !wait_q && !skip_now;
			end
			S_AG2: begin
				mreq.a     = cv_q[idx_q];
				mreq.b     = dt_q;
				mreq.start = !wait_q;
			end
			S_AG3: begin
				mreq.a     = t2_q;
				mreq.b     = dt_q;
				mreq.start = !wait_q;
			end
			S_AG4: begin
				mreq.a     = qts_pkg::sat_add(cv_q[idx_q], cv_q[idx_q]);
				mreq.b     = dt_q;
				mreq.start = !wait_q;
			end
			S_SVBB: begin
				mreq.a     = cb_q;
				mreq.b     = cb_q;
				mreq.start = !wait_q;
			end
			S_SVAC: begin
				mreq.a     = t1_q;
				mreq.b     = cc_q;
				mreq.start = !wait_q;
			end
			S_SVLIN: begin
				dreq.a     = qts_pkg::sat_neg(cc_q);
				dreq.b     = cb_q;
				dreq.start = !wait_q;
			end
			S_SVSQ: begin
				dreq.sq_mode = 1'b1;
				dreq.a       = t2_q;
				dreq.start   = !wait_q;
			end
			S_SVR1: begin
				dreq.a     = qts_pkg::div2_trunc(qts_pkg::sat_add(nb_q, sq_q));
				dreq.b     = ca_q;
				dreq.start = !wait_q;
			end
			S_SVR2: begin
				dreq.a     = qts_pkg::div2_trunc(qts_pkg::sat_sub(nb_q, sq_q));
				dreq.b     = ca_q;
				dreq.start = !wait_q;
			end
			S_INTDIV: begin
				dreq.a     = qts_pkg::sat_sub(sl_q[3], sl_q[2]);
				dreq.b     = ca_q;
				dreq.start = !wait_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			lv_q     <= '{default: '0};
			sl_q     <= '{default: '0};
			cv_q     <= '{default: '0};
			ta_q     <= NEVER;
			ct_q     <= NEVER;
			sel_q    <= 1'b0;
			chg_q    <= 1'b0;
			op_q     <= 1'b0;
			due_q    <= 1'b0;
			skip_q   <= 1'b0;
			wait_q   <= 1'b0;
			port_q   <= '0;
			idx_q    <= '0;
			nlv_q    <= '0;
			nsl_q    <= '0;
			ncv_q    <= '0;
			el_q     <= '0;
			dt_q     <= '0;
			t1_q     <= '0;
			t2_q     <= '0;
			ca_q     <= '0;
			cb_q     <= '0;
			cc_q     <= '0;
			nb_q     <= '0;
			sq_q     <= '0;
			s1_q     <= '0;
			s2_q     <= '0;
			res_ov_q <= 1'b0;
			res_lv_q <= '0;
			res_sl_q <= '0;
			res_cv_q <= '0;
		end else begin
			if (mreq.start || dreq.start) wait_q <= 1'b1;
			else if (mrsp.done || drsp.done) wait_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (evt_valid) begin
						op_q <= op;
						if (op == qts_pkg::OP_INTERNAL) begin
							if (ta_q == '0) begin
								// Switch is due now: emit the selected trajectory as is.
								res_ov_q <= 1'b1;
								res_lv_q <= lv_q[csel];
								res_sl_q <= sl_q[csel];
								res_cv_q <= cv_q[csel];
								ta_q     <= ct_q;
								chg_q    <= 1'b0;
								state_q  <= S_OUT;
							end else begin
								dt_q    <= ta_q;
								idx_q   <= '0;
								skip_q  <= 1'b0;
								state_q <= S_AG1;
							end
						end else begin
							port_q  <= port;
							nlv_q   <= level;
							nsl_q   <= slope;
							ncv_q   <= curve;
							el_q    <= {1'b0, elapsed};
							dt_q    <= {1'b0, elapsed};
							due_q   <= (ta_q == {1'b0, elapsed});
							idx_q   <= '0;
							skip_q  <= 1'b1;
							state_q <= S_AG1;
						end
					end
				end
				S_AG1: begin
					if (skip_now) state_q <= S_AGN;
					else if (mrsp.done) begin
						t1_q    <= qts_pkg::sat_add(lv_q[idx_q], mrsp.value);
						state_q <= S_AG2;
					end
				end
				S_AG2: begin
					if (mrsp.done) begin
						t2_q    <= mrsp.value;
						state_q <= S_AG3;
					end
				end
				S_AG3: begin
					if (mrsp.done) begin
						t1_q    <= qts_pkg::sat_add(t1_q, mrsp.value);
						state_q <= S_AG4;
					end
				end
				S_AG4: begin
					if (mrsp.done) begin
						sl_q[idx_q] <= qts_pkg::sat_add(sl_q[idx_q], mrsp.value);
						lv_q[idx_q] <= t1_q;
						state_q     <= S_AGN;
					end
				end
				S_AGN: begin
					if (idx_q == 2'd3)
						state_q <= (op_q == qts_pkg::OP_INTERNAL) ? S_INTAB : S_LOAD;
					else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_AG1;
					end
				end
				S_LOAD: begin
					lv_q[port_q] <= nlv_q;
					sl_q[port_q] <= nsl_q;
					cv_q[port_q] <= ncv_q;
					state_q      <= port_q[1] ? S_SV0 : S_EXT;
				end
				S_SV0: begin
					ca_q    <= qts_pkg::sat_sub(cv_q[2], cv_q[3]);
					cb_q    <= qts_pkg::sat_sub(sl_q[2], sl_q[3]);
					cc_q    <= qts_pkg::sat_sub(lv_q[2], lv_q[3]);
					state_q <= S_SVBR;
				end
				S_SVBR: begin
					if (ca_q == '0) begin
						// No curve difference: at most one linear root.
						s2_q <= NEVER;
						if (cb_q == '0) begin
							s1_q    <= NEVER;
							state_q <= S_SVPICK;
						end else state_q <= S_SVLIN;
					end else begin
						t1_q    <= qts_pkg::sat_add(qts_pkg::sat_add(ca_q, ca_q),
							qts_pkg::sat_add(ca_q, ca_q));
						state_q <= S_SVBB;
					end
				end
				S_SVLIN: begin
					if (drsp.done) begin
						s1_q    <= drsp.value;
						state_q <= S_SVPICK;
					end
				end
				S_SVBB: begin
					if (mrsp.done) begin
						t2_q    <= mrsp.value;
						state_q <= S_SVAC;
					end
				end
				S_SVAC: begin
					if (mrsp.done) begin
						t2_q    <= qts_pkg::sat_sub(t2_q, mrsp.value);
						state_q <= S_SVDISC;
					end
				end
				S_SVDISC: begin
					nb_q <= qts_pkg::sat_neg(cb_q);
					if (t2_q[63]) begin
						// Negative discriminant: the trajectories never cross.
						ct_q    <= NEVER;
						state_q <= S_EXT;
					end else state_q <= S_SVSQ;
				end
				S_SVSQ: begin
					if (drsp.done) begin
						sq_q    <= drsp.value;
						state_q <= S_SVR1;
					end
				end
				S_SVR1: begin
					if (drsp.done) begin
						s1_q    <= drsp.value;
						state_q <= S_SVR2;
					end
				end
				S_SVR2: begin
					if (drsp.done) begin
						s2_q    <= drsp.value;
						state_q <= S_SVPICK;
					end
				end
				S_SVPICK: begin
					// Earliest root in the future wins.
					if ((s1_q > 64'sd0) && ((s1_q < s2_q) || s2_q[63])) ct_q <= s1c;
					else if (s2_q > 64'sd0) ct_q <= s2c;
					else ct_q <= NEVER;
					state_q <= S_EXT;
				end
				S_EXT: begin
					res_ov_q <= 1'b0;
					res_lv_q <= '0;
					res_sl_q <= '0;
					res_cv_q <= '0;
					if (port_q[1]) begin
						if (due_q && ((gt23 && !sel_q) || (lt23 && sel_q))) ta_q <= '0;
						else if ((gt23 && sel_q) || (lt23 && !sel_q)) begin
							sel_q <= ~sel_q;
							chg_q <= 1'b1;
							ta_q  <= '0;
						end else ta_q <= ct_q;
					end else begin
						ct_q <= ct_dec;
						if (due_q) ta_q <= ((sel_q == port_q[0]) || chg_q) ? '0 : ct_dec;
						else if (gt23 && !port_q[0]) begin
							ta_q  <= '0;
							sel_q <= 1'b0;
						end else if (lt23 && port_q[0]) begin
							ta_q  <= '0;
							sel_q <= 1'b1;
						end else ta_q <= ct_dec;
					end
					state_q <= S_OUT;
				end
				S_INTAB: begin
					ca_q    <= qts_pkg::sat_sub(cv_q[2], cv_q[3]);
					cb_q    <= qts_pkg::sat_sub(sl_q[2], sl_q[3]);
					state_q <= S_INTBR;
				end
				S_INTBR: begin
					if (int_cross) state_q <= S_INTDIV;
					else begin
						ta_q    <= NEVER;
						ct_q    <= NEVER;
						state_q <= S_INTFIN;
					end
				end
				S_INTDIV: begin
					if (drsp.done) begin
						ta_q    <= div_c;
						ct_q    <= div_c;
						state_q <= S_INTFIN;
					end
				end
				S_INTFIN: begin
					// The other trajectory, already aged to now, becomes the output.
					res_ov_q <= 1'b1;
					res_lv_q <= lv_q[ksel];
					res_sl_q <= sl_q[ksel];
					res_cv_q <= cv_q[ksel];
					sel_q    <= ~sel_q;
					chg_q    <= 1'b0;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!res_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt_stall = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign out_valid = res_ov_q;
	assign out_level = res_lv_q;
	assign out_slope = res_sl_q;
	assign out_curve = res_cv_q;
	assign next_time = ta_q[63] ? '0 : ta_q[62:0];

endmodule

### hdl/qts_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_mul - iterative saturating fixed point multiplier
// Forms the 128-bit magnitude product from four 32x32 partial products,
// one per cycle, then rescales and saturates to the signed 64-bit range.
// ----------------------------------------------------------------------------
module qts_mul #(
	parameter int FRAC_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qts_pkg::mul_req_t   req,
	output qts_pkg::unit_rsp_t  rsp
);

	logic          busy_q, fin_q, done_q, neg_q;
	logic [2:0]    ph_q;
	logic [1:0]    sh_q;
	logic [63:0]   ma_q, mb_q, pp_q, m;
	logic [127:0]  acc_q, shifted;
	logic [31:0]   opa, opb;
	qts_pkg::q_t   res_q;

	always_comb begin
		opa = ph_q[1] ? ma_q[63:32] : ma_q[31:0];
		opb = ph_q[0] ? mb_q[63:32] : mb_q[31:0];
		unique case (sh_q)
			2'd0:       shifted = {64'd0, pp_q};
			2'd3:       shifted = {pp_q, 64'd0};
			default:    shifted = {32'd0, pp_q, 32'd0};
		endcase
		m = (|acc_q[127:64+FRAC_BITS]) ? '1 : acc_q[FRAC_BITS+63:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			ph_q   <= '0;
			sh_q   <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
			pp_q   <= '0;
			acc_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				ma_q   <= qts_pkg::mag(req.a);
				mb_q   <= qts_pkg::mag(req.b);
				neg_q  <= req.a[63] ^ req.b[63];
				acc_q  <= '0;
				ph_q   <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ph_q != 3'd4) begin
					pp_q <= opa * opb;
					sh_q <= ph_q[1:0];
				end
				if (ph_q != 3'd0) acc_q <= acc_q + shifted;
				if (ph_q == 3'd4) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
				ph_q <= ph_q + 3'd1;
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				res_q  <= qts_pkg::from_mag(neg_q, m);
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

### hdl/qts_dsq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_dsq - shared divider and square root unit
// Restoring division of the rescaled dividend and digit by digit square
// root of the rescaled radicand, one result bit per cycle through one
// shared subtractor.
// ----------------------------------------------------------------------------
module qts_dsq #(
	parameter int FRAC_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qts_pkg::dsq_req_t   req,
	output qts_pkg::unit_rsp_t  rsp
);

	logic          busy_q, fin_q, done_q, sqm_q, neg_q;
	logic [6:0]    cnt_q;
	logic [127:0]  num_q, nwide, swide;
	logic [66:0]   rem_q, r2, trial;
	logic [67:0]   diff;
	logic [63:0]   root_q, mb_q, ma, mbi;
	qts_pkg::q_t   res_q;

	always_comb begin
		ma    = qts_pkg::mag(req.a);
		mbi   = qts_pkg::mag(req.b);
		nwide = {64'd0, ma} << FRAC_BITS;
		swide = {64'd0, req.a} << FRAC_BITS;
		r2    = sqm_q ? {rem_q[64:0], num_q[127:126]} : {rem_q[65:0], num_q[127]};
		trial = sqm_q ? {1'b0, root_q, 2'b01} : {3'b000, mb_q};
		diff  = {1'b0, r2} - {1'b0, trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			sqm_q  <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			mb_q   <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				sqm_q  <= req.sq_mode;
				neg_q  <= req.a[63] ^ req.b[63];
				mb_q   <= mbi;
				root_q <= '0;
				cnt_q  <= 7'd64;
				if (req.sq_mode) begin
					if (req.a[63] || (req.a == '0)) begin
						res_q  <= '0;
						done_q <= 1'b1;
					end else begin
						num_q  <= swide;
						rem_q  <= '0;
						busy_q <= 1'b1;
					end
				end else begin
					if (ma == '0) begin
						res_q  <= '0;
						done_q <= 1'b1;
					end else if (nwide[127:64] >= mbi) begin
						// Quotient does not fit, also taken for a zero divisor.
						res_q  <= qts_pkg::from_mag(req.a[63] ^ req.b[63], '1);
						done_q <= 1'b1;
					end else begin
						num_q  <= {nwide[63:0], 64'd0};
						rem_q  <= {3'b000, nwide[127:64]};
						busy_q <= 1'b1;
					end
				end
			end else if (busy_q) begin
				if (!diff[67]) begin
					rem_q  <= diff[66:0];
					root_q <= {root_q[62:0], 1'b1};
				end else begin
					rem_q  <= r2;
					root_q <= {root_q[62:0], 1'b0};
				end
				num_q <= sqm_q ? (num_q << 2) : (num_q << 1);
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				res_q  <= qts_pkg::from_mag(sqm_q ? 1'b0 : neg_q, root_q);
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = res_q;

endmodule

### hdl/qts_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qts_check - port level checks of the trajectory switch
// Watches the event and result channels of the top level over time.
// ----------------------------------------------------------------------------
module qts_check (
	input logic               clk,
	input logic               arst_n,
	input logic               evt_valid,
	input logic               evt_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic               out_valid,
	input logic signed [63:0] out_level,
	input logic signed [63:0] out_slope,
	input logic signed [63:0] out_curve,
	input logic [62:0]        next_time
);

	// An accepted event blocks the next one until its result is out.
	a_evt_block: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_stall |=> evt_stall)
		else $error("event accepted while previous event still in flight");

	// Only one event is ever in flight.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> evt_stall)
		else $error("input open while a result is pending");

	// A stalled result beat holds its contents.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_level) &&
		$stable(out_slope) && $stable(out_curve) && $stable(next_time) &&
		$stable(out_valid))
		else $error("stalled result changed");

	// External events emit nothing.
	a_ext_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> (out_level == '0) && (out_slope == '0) &&
		(out_curve == '0))
		else $error("non-emitting result carries coefficients");

endmodule

bind quadratic_trajectory_switch_unit qts_check u_qts_check (.*);

### dv/tb_quadratic_trajectory_switch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_trajectory_switch_unit - event-level check of the trajectory switch
// Drives external and internal events into the switch and predicts every
// result beat with a bit-exact model of the saturating Q32.32 datapath. The
// sender and the receiver both idle at random, and the receiver stalls for
// a long stretch once. Each result beat is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_quadratic_trajectory_switch_unit;

	localparam int FRAC = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic        valid;
		qts_pkg::q_t lvl;
		qts_pkg::q_t slp;
		qts_pkg::q_t crv;
		logic [62:0] nt;
	} emission_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	logic op = 1'b0;
	logic [1:0] port = '0;
	logic signed [63:0] level = '0, slope = '0, curve = '0;
	logic [62:0] elapsed = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic out_valid;
	logic signed [63:0] out_level, out_slope, out_curve;
	logic [62:0] next_time;

	quadratic_trajectory_switch_unit #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n), .evt_valid(evt_valid), .evt_stall(evt_stall),
		.op(op), .port(port), .level(level), .slope(slope), .curve(curve),
		.elapsed(elapsed), .res_valid(res_valid), .res_stall(res_stall),
		.out_valid(out_valid), .out_level(out_level), .out_slope(out_slope),
		.out_curve(out_curve), .next_time(next_time)
	);

	always #5 clk = ~clk;

	// Predictor state, a private copy of the switch's trajectories.
	qts_pkg::q_t traj_lvl[4], traj_slp[4], traj_crv[4];
	qts_pkg::q_t advance, crossing;
	logic sel, switched;
	emission_t pending[$];

	int mismatches = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;       // no random idling while set
	bit hold_off = 1'b0;    // long receiver stall request

	function automatic qts_pkg::q_t never_time();
		if (qts_pkg::NEVER_INT > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC)) return qts_pkg::Q_MAX;
		return qts_pkg::q_t'(qts_pkg::NEVER_INT << FRAC);
	endfunction

	function automatic logic [63:0] magnitude(input qts_pkg::q_t a);
		return a[63] ? 64'd0 - a : a;
	endfunction

	function automatic qts_pkg::q_t signed_sat(input logic neg, input logic [63:0] m);
		if (neg) return m[63] ? qts_pkg::Q_MIN : qts_pkg::q_t'(64'd0 - m);
		return m[63] ? qts_pkg::Q_MAX : qts_pkg::q_t'(m);
	endfunction

	function automatic qts_pkg::q_t add_sat(input qts_pkg::q_t a, input qts_pkg::q_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? qts_pkg::Q_MIN : qts_pkg::Q_MAX;
		return s[63:0];
	endfunction

	function automatic qts_pkg::q_t sub_sat(input qts_pkg::q_t a, input qts_pkg::q_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? qts_pkg::Q_MIN : qts_pkg::Q_MAX;
		return s[63:0];
	endfunction

	function automatic qts_pkg::q_t neg_sat(input qts_pkg::q_t a);
		return (a == qts_pkg::Q_MIN) ? qts_pkg::Q_MAX : qts_pkg::q_t'(64'd0 - a);
	endfunction

	function automatic qts_pkg::q_t fx_mul(input qts_pkg::q_t a, input qts_pkg::q_t b);
		logic [127:0] p;
		logic [63:0] m;
		p = magnitude(a) * magnitude(b);
		if ((p >> (64 + FRAC)) != 0) m = '1;
		else m = p[63 + FRAC -: 64];
		return signed_sat(a[63] ^ b[63], m);
	endfunction

	function automatic qts_pkg::q_t fx_div(input qts_pkg::q_t a, input qts_pkg::q_t b);
		logic [127:0] num, q;
		if (b == 0)
			return (a == 0) ? qts_pkg::q_t'(0) : (a[63] ? qts_pkg::Q_MIN : qts_pkg::Q_MAX);
		num = {64'd0, magnitude(a)} << FRAC;
		q = num / magnitude(b);
		// the quotient search only spans 64 bits
		if (q[127:64] != 0) q = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
		return signed_sat(a[63] ^ b[63], q[63:0]);
	endfunction

	function automatic qts_pkg::q_t fx_sqrt(input qts_pkg::q_t d);
		logic [127:0] num, prod;
		logic [63:0] r, c;
		if (d <= 0) return 0;
		num = {64'd0, d} << FRAC;
		r = 0;
		for (int bit_i = 63; bit_i >= 0; bit_i--) begin
			c = r | (64'd1 << bit_i);
			prod = c * c;
			if (prod <= num) r = c;
		end
		return signed_sat(1'b0, r);
	endfunction

	function automatic qts_pkg::q_t half_trunc(input qts_pkg::q_t a);
		return a[63] ? qts_pkg::q_t'((a + 64'sd1) >>> 1) : qts_pkg::q_t'(a >>> 1);
	endfunction

	function automatic qts_pkg::q_t clamp_to_never(input qts_pkg::q_t t);
		return (t > never_time()) ? never_time() : t;
	endfunction

	function automatic qts_pkg::q_t level_at(input int i, input qts_pkg::q_t dt);
		return add_sat(add_sat(traj_lvl[i], fx_mul(traj_slp[i], dt)),
			fx_mul(fx_mul(traj_crv[i], dt), dt));
	endfunction

	function automatic qts_pkg::q_t slope_at(input int i, input qts_pkg::q_t dt);
		return add_sat(traj_slp[i], fx_mul(add_sat(traj_crv[i], traj_crv[i]), dt));
	endfunction

	function automatic void advance_traj(input int i, input qts_pkg::q_t dt);
		qts_pkg::q_t lv;
		lv = level_at(i, dt);
		traj_slp[i] = slope_at(i, dt);
		traj_lvl[i] = lv;
	endfunction

	function automatic void reset_model();
		for (int i = 0; i < 4; i++) begin
			traj_lvl[i] = 0;
			traj_slp[i] = 0;
			traj_crv[i] = 0;
		end
		advance = never_time();
		crossing = never_time();
		sel = 1'b0;
		switched = 1'b0;
	endfunction

	// Earliest positive time at which trajectory 2 meets trajectory 3.
	function automatic void solve_crossing();
		qts_pkg::q_t a, b, c, r1, r2, disc, root, a4;
		a = sub_sat(traj_crv[2], traj_crv[3]);
		b = sub_sat(traj_slp[2], traj_slp[3]);
		c = sub_sat(traj_lvl[2], traj_lvl[3]);
		if (a == 0) begin
			r2 = never_time();
			r1 = (b == 0) ? never_time() : fx_div(neg_sat(c), b);
		end else begin
			a4 = add_sat(add_sat(a, a), add_sat(a, a));
			disc = sub_sat(fx_mul(b, b), fx_mul(a4, c));
			if (disc < 0) begin
				crossing = never_time();
				return;
			end
			root = fx_sqrt(disc);
			r1 = fx_div(half_trunc(add_sat(neg_sat(b), root)), a);
			r2 = fx_div(half_trunc(sub_sat(neg_sat(b), root)), a);
		end
		if (r1 > 0 && (r1 < r2 || r2 < 0)) crossing = clamp_to_never(r1);
		else if (r2 > 0) crossing = clamp_to_never(r2);
		else crossing = never_time();
	endfunction

	function automatic void external_event(input logic [1:0] p, input qts_pkg::q_t lv,
		input qts_pkg::q_t sl, input qts_pkg::q_t cv, input qts_pkg::q_t e);
		bit due;
		due = (advance == e);
		for (int i = 0; i < 4; i++)
			if (i != p) advance_traj(i, e);
		traj_lvl[p] = lv;
		traj_slp[p] = sl;
		traj_crv[p] = cv;
		if (p >= 2) begin
			solve_crossing();
			if (due && ((traj_lvl[2] > traj_lvl[3] && !sel) ||
				(traj_lvl[3] > traj_lvl[2] && sel))) begin
				advance = 0;
			end else if ((traj_lvl[2] > traj_lvl[3] && sel) ||
				(traj_lvl[2] < traj_lvl[3] && !sel)) begin
				sel = ~sel;
				switched = 1'b1;
				advance = 0;
			end else begin
				advance = crossing;
			end
		end else begin
			if (crossing != never_time()) begin
				crossing = sub_sat(crossing, e);
				if (crossing < 0) crossing = 0;
			end
			if (due) begin
				advance = (p == {1'b0, sel} || switched) ? qts_pkg::q_t'(0) : crossing;
			end else if (traj_lvl[2] > traj_lvl[3] && p == 0) begin
				advance = 0;
				sel = 1'b0;
			end else if (traj_lvl[2] < traj_lvl[3] && p == 1) begin
				advance = 0;
				sel = 1'b1;
			end else begin
				advance = crossing;
			end
		end
	endfunction

	// Works out the result of one event and moves the model on.
	function automatic emission_t predict_emission(input logic o, input logic [1:0] p,
		input qts_pkg::q_t lv, input qts_pkg::q_t sl, input qts_pkg::q_t cv,
		input logic [62:0] e);
		emission_t r;
		qts_pkg::q_t t, a, b;
		int k;
		r = '0;
		if (o == qts_pkg::OP_EXTERNAL) begin
			external_event(p, lv, sl, cv, qts_pkg::q_t'({1'b0, e}));
		end else begin
			r.valid = 1'b1;
			t = advance;
			if (t == 0) begin
				r.lvl = traj_lvl[sel];
				r.slp = traj_slp[sel];
				r.crv = traj_crv[sel];
				advance = crossing;
			end else begin
				k = sel ? 0 : 1;
				r.lvl = level_at(k, t);
				r.slp = slope_at(k, t);
				r.crv = traj_crv[k];
				for (int i = 0; i < 4; i++) advance_traj(i, t);
				a = sub_sat(traj_crv[2], traj_crv[3]);
				b = sub_sat(traj_slp[2], traj_slp[3]);
				if ((b < 0 && a > 0) || (b > 0 && a < 0))
					advance = clamp_to_never(fx_div(sub_sat(traj_slp[3], traj_slp[2]), a));
				else
					advance = never_time();
				crossing = advance;
				sel = ~sel;
			end
			switched = 1'b0;
		end
		r.nt = advance[63] ? 63'd0 : advance[62:0];
		return r;
	endfunction

	function automatic qts_pkg::q_t rand_q();
		case ($urandom_range(0, 5))
			0: return qts_pkg::q_t'({$urandom, $urandom});
			1: return qts_pkg::q_t'($signed($urandom_range(0, 20)) - 10) <<< FRAC;
			2: return qts_pkg::q_t'($signed($urandom)) <<< ($urandom_range(0, 24));
			3: return $urandom_range(0, 1) ? qts_pkg::Q_MAX : qts_pkg::Q_MIN;
			default: return qts_pkg::q_t'($signed($urandom_range(0, 65535)) - 32768) <<< 20;
		endcase
	endfunction

	// Sends one event beat and records its prediction when it is taken. The
	// beat stays offered until the next falling edge, where the next call or
	// the end of the test replaces or drops it.
	task automatic send_event(input logic o, input logic [1:0] p, input qts_pkg::q_t lv,
		input qts_pkg::q_t sl, input qts_pkg::q_t cv, input logic [62:0] e);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 6) begin
			evt_valid <= 1'b0;
			@(negedge clk);
		end
		op <= o;
		port <= p;
		level <= lv;
		slope <= sl;
		curve <= cv;
		elapsed <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (evt_stall);
		pending.push_back(predict_emission(o, p, lv, sl, cv, e));
	endtask

	// Elapsed time that often hits the scheduled advance.
	function automatic logic [62:0] pick_elapsed();
		case ($urandom_range(0, 4))
			0: return advance[63] ? 63'd0 : advance[62:0];
			1: return 63'({$urandom, $urandom});
			2: return 63'd0;
			default: return 63'($urandom_range(0, 1 << 20)) << 16;
		endcase
	endfunction

	task automatic test_directed();
		qts_pkg::q_t one;
		one = qts_pkg::q_t'(64'sd1) <<< FRAC;
		send_event(qts_pkg::OP_INTERNAL, 2'd0, 0, 0, 0, 0);             // internal while idle
		send_event(qts_pkg::OP_EXTERNAL, 2'd0, qts_pkg::Q_MAX, qts_pkg::Q_MIN,
			qts_pkg::Q_MAX, 63'h7FFF_FFFF_FFFF_FFFF);
		send_event(qts_pkg::OP_EXTERNAL, 2'd1, qts_pkg::Q_MIN, qts_pkg::Q_MAX,
			qts_pkg::Q_MIN, 0);
		// Zero curve difference, linear crossing.
		send_event(qts_pkg::OP_EXTERNAL, 2'd2, 0, one, 0, one);
		send_event(qts_pkg::OP_EXTERNAL, 2'd3, one, 0, 0, 0);
		send_event(qts_pkg::OP_INTERNAL, 2'd3, -1, -1, -1, '1);
		send_event(qts_pkg::OP_INTERNAL, 2'd0, 0, 0, 0, 0);
		// Negative discriminant: no crossing.
		send_event(qts_pkg::OP_EXTERNAL, 2'd2, one, 0, one, 0);
		// Zero curve and slope difference.
		send_event(qts_pkg::OP_EXTERNAL, 2'd3, 0, 0, one, 0);
		// Root far beyond never.
		send_event(qts_pkg::OP_EXTERNAL, 2'd2, 0, 64'sd1, one, 0);
		send_event(qts_pkg::OP_EXTERNAL, 2'd0, one, one, 0, 63'd5 << FRAC);
		// Compare at due time.
		send_event(qts_pkg::OP_EXTERNAL, 2'd2, one <<< 2, 0, -one, pick_elapsed());
		send_event(qts_pkg::OP_EXTERNAL, 2'd3, one <<< 3, one, one, pick_elapsed());
		send_event(qts_pkg::OP_EXTERNAL, 2'd1, 0, -one, one, pick_elapsed());
		send_event(qts_pkg::OP_INTERNAL, 2'd0, 0, 0, 0, 0);
		send_event(qts_pkg::OP_INTERNAL, 2'd0, 0, 0, 0, 0);
		send_event(qts_pkg::OP_EXTERNAL, 2'd0, -one, one, 0, pick_elapsed());
		send_event(qts_pkg::OP_INTERNAL, 2'd0, 0, 0, 0, 0);
	endtask

	task automatic test_random(input int count);
		logic o;
		for (int n = 0; n < count; n++) begin
			o = ($urandom_range(0, 99) < 35) ? qts_pkg::OP_INTERNAL : qts_pkg::OP_EXTERNAL;
			send_event(o, 2'($urandom), rand_q(), rand_q(), rand_q(),
				(o == qts_pkg::OP_INTERNAL) ? 63'({$urandom, $urandom}) : pick_elapsed());
		end
	endtask

	// Quiet stretch with no idling on either side.
	task automatic test_back_to_back(input int count);
		quiet = 1'b1;
		test_random(count);
		quiet = 1'b0;
	endtask

	// Receiver holds off while the sender keeps offering events.
	task automatic test_backpressure();
		hold_off = 1'b1;
		test_random(4);
		hold_off = 1'b0;
	endtask

	// Result checker.
	always @(posedge clk) begin
		emission_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
			end else begin
				exp_r = pending.pop_front();
				if (out_valid !== exp_r.valid || out_level !== exp_r.lvl ||
					out_slope !== exp_r.slp || out_curve !== exp_r.crv ||
					next_time !== exp_r.nt) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch at %0t: exp v=%0b l=%h s=%h c=%h t=%h,",
							" got v=%0b l=%h s=%h c=%h t=%h"},
							$realtime, exp_r.valid, exp_r.lvl, exp_r.slp, exp_r.crv, exp_r.nt,
							out_valid, out_level, out_slope, out_curve, next_time);
				end
			end
		end
	end

	// Receiver stall: random short stalls, plus one long hold-off.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				res_stall <= 1'b1;
				for (hold = 0; hold < 600; hold++) @(negedge clk);
				res_stall <= 1'b0;
				wait (!hold_off);
			end else begin
				res_stall <= (!quiet && $urandom_range(0, 99) < 6);
			end
		end
	end

	// Watchdog: cycles with no beat accepted on either channel.
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int wait_cycles;
		reset_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(900);
		test_backpressure();
		test_back_to_back(200);
		test_random(730);
		@(negedge clk);
		evt_valid <= 1'b0;
		while (pending.size() != 0) @(negedge clk);
		for (wait_cycles = 0; wait_cycles < 400; wait_cycles++) @(negedge clk);
		if (mismatches == 0 && pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### sim.f
hdl/qts_pkg.sv
hdl/qts_mul.sv
hdl/qts_dsq.sv
hdl/quadratic_trajectory_switch_unit.sv
hdl/qts_check.sv
dv/tb_quadratic_trajectory_switch_unit.sv
